[rtl/rgb565_window_bus_writer_top_macros.svh]
// Assertion macros used by the top level of the window bus writer.
`ifndef RGB565_WINDOW_BUS_WRITER_TOP_MACROS_SVH
`define RGB565_WINDOW_BUS_WRITER_TOP_MACROS_SVH

// Same-cycle implication, checked only while out of reset.
`define RGBW_ASSERT_NOW(label, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (lhs) |-> (rhs)) \
		else $error("rgbw same-cycle check failed");

// Next-cycle implication, checked only while out of reset.
`define RGBW_ASSERT_NEXT(label, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (lhs) |=> (rhs)) \
		else $error("rgbw next-cycle check failed");

`endif

[rtl/rgbw_pkg.sv]
// Types, constants and codes shared by the window bus writer modules.
package rgbw_pkg;

	// Coordinate width and derived widths.
	localparam int COORD_BITS     = 11;
	localparam int PIX_CNT_BITS   = 2 * COORD_BITS;
	localparam int PIXEL_BITS     = 16;
	localparam int CFG_INDEX_BITS = 1;
	localparam int CFG_DATA_BITS  = COORD_BITS;
	localparam int STEP_BITS      = 4;
	localparam int QUEUE_DEPTH    = 4;
	localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

	// Register indexes of the configuration port.
	localparam logic [CFG_INDEX_BITS-1:0] REG_PANEL_WIDTH  = CFG_INDEX_BITS'(0);
	localparam logic [CFG_INDEX_BITS-1:0] REG_PANEL_HEIGHT = CFG_INDEX_BITS'(1);

	// Register reset values.
	localparam logic [COORD_BITS-1:0] PANEL_WIDTH_RESET  = COORD_BITS'(800);
	localparam logic [COORD_BITS-1:0] PANEL_HEIGHT_RESET = COORD_BITS'(480);

	// Input item modes.
	localparam logic MODE_WINDOW = 1'b0;
	localparam logic MODE_PIXEL  = 1'b1;

	// Result status codes.
	localparam logic [1:0] STATUS_OK         = 2'd0;
	localparam logic [1:0] STATUS_BAD_WINDOW = 2'd1;
	localparam logic [1:0] STATUS_NO_WINDOW  = 2'd2;

	// Controller command bytes and colour masks.
	localparam logic [7:0] CMD_COLUMN_SET = 8'h2A;
	localparam logic [7:0] CMD_PAGE_SET   = 8'h2B;
	localparam logic [7:0] CMD_MEM_WRITE  = 8'h2C;
	localparam logic [7:0] MASK_FIVE_BIT  = 8'hF8;
	localparam logic [7:0] MASK_SIX_BIT   = 8'hFC;

	// Last sequence step of each operation kind.
	localparam logic [STEP_BITS-1:0] WINDOW_LAST_STEP = STEP_BITS'(10);
	localparam logic [STEP_BITS-1:0] PIXEL_LAST_STEP  = STEP_BITS'(2);

	// Input item as it arrives on the port.
	typedef struct packed {
		logic                  mode;
		logic [COORD_BITS-1:0] x_start;
		logic [COORD_BITS-1:0] y_start;
		logic [COORD_BITS-1:0] win_width;
		logic [COORD_BITS-1:0] win_height;
		logic [PIXEL_BITS-1:0] pixel;
	} in_item_t;

	// Result item as it leaves on the port.
	typedef struct packed {
		logic       is_command;
		logic [7:0] bus_byte;
		logic [1:0] status;
		logic       last_of_run;
		logic       window_done;
	} out_item_t;

	// Kind of work the back end has to carry out.
	typedef enum logic [1:0] {
		OP_WINDOW,
		OP_PIXEL,
		OP_BAD_WINDOW,
		OP_NO_WINDOW
	} op_kind_t;

	// Classified item held in the queue between front and back.
	typedef struct packed {
		op_kind_t              kind;
		logic [COORD_BITS-1:0] x_first;
		logic [COORD_BITS-1:0] x_last;
		logic [COORD_BITS-1:0] y_first;
		logic [COORD_BITS-1:0] y_last;
		logic [PIXEL_BITS-1:0] pixel;
		logic                  done;
	} op_t;

	// Handshake between the queue and the back end.
	typedef struct packed {
		logic valid;
		op_t  op;
	} queue_head_t;

endpackage

[rtl/rgbw_front.sv]
// Front end: configuration registers, window checks and pixel bookkeeping.
module rgbw_front
	import rgbw_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  in_item_t                  in_item,
	input  logic                      queue_ready,
	output logic                      push,
	output op_t                       push_op
);

	logic [COORD_BITS-1:0]   panel_width_q;
	logic [COORD_BITS-1:0]   panel_height_q;
	logic                    window_open_q;
	logic [PIX_CNT_BITS-1:0] pixels_left_q;

	logic [COORD_BITS:0]     x_sum;
	logic [COORD_BITS:0]     y_sum;
	logic                    reject;
	logic [PIX_CNT_BITS-1:0] area;
	logic [PIX_CNT_BITS-1:0] left_dec;

	// Configuration writes; indexes beyond the list fall through.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			panel_width_q  <= PANEL_WIDTH_RESET;
			panel_height_q <= PANEL_HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PANEL_WIDTH:  panel_width_q  <= cfg_data;
				REG_PANEL_HEIGHT: panel_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Window check against the panel size, and the window's pixel count.
	always_comb begin
		x_sum    = {1'b0, in_item.x_start} + {1'b0, in_item.win_width};
		y_sum    = {1'b0, in_item.y_start} + {1'b0, in_item.win_height};
		reject   = (in_item.win_width == '0) || (in_item.win_height == '0) ||
		           (x_sum > {1'b0, panel_width_q}) || (y_sum > {1'b0, panel_height_q});
		area     = PIX_CNT_BITS'(in_item.win_width) * PIX_CNT_BITS'(in_item.win_height);
		left_dec = pixels_left_q - PIX_CNT_BITS'(1);
	end

	assign in_ready = queue_ready;
	assign push     = in_valid && queue_ready;

	// Classification of the item into the operation for the back end.
	always_comb begin
		push_op.x_first = in_item.x_start;
		push_op.x_last  = COORD_BITS'(x_sum - (COORD_BITS + 1)'(1));
		push_op.y_first = in_item.y_start;
		push_op.y_last  = COORD_BITS'(y_sum - (COORD_BITS + 1)'(1));
		push_op.pixel   = in_item.pixel;
		push_op.done    = (left_dec == '0);
		if (in_item.mode == MODE_WINDOW) begin
			push_op.kind = reject ? OP_BAD_WINDOW : OP_WINDOW;
		end else begin
			push_op.kind = window_open_q ? OP_PIXEL : OP_NO_WINDOW;
		end
	end

	// Window state follows each accepted item in order.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_open_q <= 1'b0;
			pixels_left_q <= '0;
		end else if (push) begin
			if (in_item.mode == MODE_WINDOW) begin
				if (!reject) begin
					window_open_q <= 1'b1;
					pixels_left_q <= area;
				end
			end else if (window_open_q) begin
				pixels_left_q <= left_dec;
				if (left_dec == '0) begin
					window_open_q <= 1'b0;
				end
			end
		end
	end

endmodule

[rtl/rgbw_queue.sv]
// Short queue of classified items between the front and the back end.
module rgbw_queue
	import rgbw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  op_t         push_op,
	output logic        ready,
	input  logic        pop,
	output queue_head_t head
);

	op_t                     entry_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_BITS-1:0] wr_ptr_q;
	logic [QUEUE_PTR_BITS-1:0] rd_ptr_q;
	logic [QUEUE_PTR_BITS:0]   count_q;

	assign ready      = (count_q != (QUEUE_PTR_BITS + 1)'(QUEUE_DEPTH));
	assign head.valid = (count_q != '0);
	assign head.op    = entry_q[rd_ptr_q];

	// Entry storage; payload needs no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_PTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_PTR_BITS'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QUEUE_PTR_BITS + 1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QUEUE_PTR_BITS + 1)'(1);
			end
		end
	end

endmodule

[rtl/rgbw_back.sv]
// Back end: expands each classified item into bus bytes, one per cycle while the receiver takes them.
module rgbw_back
	import rgbw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  queue_head_t head,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_item
);

	logic                 busy_q;
	op_t                  cur_q;
	logic [STEP_BITS-1:0] step_q;
	logic                 out_valid_q;
	out_item_t            out_q;

	logic                 emit;
	logic                 last_step;
	out_item_t            next_out;

	// Byte for the current step of the current operation.
	always_comb begin
		next_out             = '0;
		next_out.status      = STATUS_OK;
		last_step            = 1'b1;
		case (cur_q.kind)
			OP_WINDOW: begin
				last_step = (step_q == WINDOW_LAST_STEP);
				case (step_q)
					STEP_BITS'(0): begin
						next_out.is_command = 1'b1;
						next_out.bus_byte   = CMD_COLUMN_SET;
					end
					STEP_BITS'(1): next_out.bus_byte = 8'(cur_q.x_first >> 8);
					STEP_BITS'(2): next_out.bus_byte = 8'(cur_q.x_first);
					STEP_BITS'(3): next_out.bus_byte = 8'(cur_q.x_last >> 8);
					STEP_BITS'(4): next_out.bus_byte = 8'(cur_q.x_last);
					STEP_BITS'(5): begin
						next_out.is_command = 1'b1;
						next_out.bus_byte   = CMD_PAGE_SET;
					end
					STEP_BITS'(6): next_out.bus_byte = 8'(cur_q.y_first >> 8);
					STEP_BITS'(7): next_out.bus_byte = 8'(cur_q.y_first);
					STEP_BITS'(8): next_out.bus_byte = 8'(cur_q.y_last >> 8);
					STEP_BITS'(9): next_out.bus_byte = 8'(cur_q.y_last);
					default: begin
						next_out.is_command  = 1'b1;
						next_out.bus_byte    = CMD_MEM_WRITE;
						next_out.last_of_run = 1'b1;
					end
				endcase
			end
			OP_PIXEL: begin
				last_step = (step_q == PIXEL_LAST_STEP);
				case (step_q)
					STEP_BITS'(0): next_out.bus_byte = cur_q.pixel[15:8] & MASK_FIVE_BIT;
					STEP_BITS'(1): next_out.bus_byte = cur_q.pixel[10:3] & MASK_SIX_BIT;
					default: begin
						next_out.bus_byte    = {cur_q.pixel[4:0], 3'b000};
						next_out.last_of_run = 1'b1;
						next_out.window_done = cur_q.done;
					end
				endcase
			end
			OP_BAD_WINDOW: begin
				next_out.status      = STATUS_BAD_WINDOW;
				next_out.last_of_run = 1'b1;
			end
			default: begin
				next_out.status      = STATUS_NO_WINDOW;
				next_out.last_of_run = 1'b1;
			end
		endcase
	end

	// A byte moves into the output register whenever that register is free.
	assign emit = busy_q && (!out_valid_q || out_ready);
	assign pop  = head.valid && (!busy_q || (emit && last_step));

	// Sequencer over the steps of the current operation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (pop) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (emit) begin
			if (last_step) begin
				busy_q <= 1'b0;
			end else begin
				step_q <= step_q + STEP_BITS'(1);
			end
		end
	end

	// Current operation payload.
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head.op;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= next_out;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

[rtl/rgb565_window_bus_writer_top.sv]
// Top level of the RGB565 window bus writer: front end, item queue and back end.
// Turns window and pixel items into command and data bytes for an 8080-style
// display bus. A valid window item produces eleven results (column set, page set,
// memory write), a pixel item three (red, green, blue widened to eight bits), and a
// rejected window or a pixel with no window open produces one status result. The
// back end places one byte in its output register per cycle while the receiver takes
// them. The front end classifies and accepts one item per cycle while a four-entry
// queue has room, so window checks and pixel counting run ahead of the bus. No
// clearing pass follows reset.
`include "rgb565_window_bus_writer_top_macros.svh"

module rgb565_window_bus_writer_top
	import rgbw_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  in_item_t                  in_item,
	output logic                      out_valid,
	input  logic                      out_ready,
	output out_item_t                 out_item
);

	logic        queue_ready;
	logic        push;
	op_t         push_op;
	logic        pop;
	queue_head_t head;

	// Front end: classifies items and keeps the window state.
	rgbw_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_item     (in_item),
		.queue_ready (queue_ready),
		.push        (push),
		.push_op     (push_op)
	);

	// Queue of classified items.
	rgbw_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.ready   (queue_ready),
		.pop     (pop),
		.head    (head)
	);

	// Back end: byte sequencer and output register.
	rgbw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	// An error status stands alone: one result, no byte.
	`RGBW_ASSERT_NOW(a_error_alone, out_valid && (out_item.status != STATUS_OK), out_item.last_of_run && !out_item.is_command && (out_item.bus_byte == 8'h00))

	// Window end is only flagged on the closing byte of a pixel.
	`RGBW_ASSERT_NOW(a_done_on_last, out_valid && out_item.window_done, out_item.last_of_run && !out_item.is_command && (out_item.status == STATUS_OK))

	// A command byte is one of the three window commands.
	`RGBW_ASSERT_NOW(a_command_code, out_valid && out_item.is_command, (out_item.bus_byte == CMD_COLUMN_SET) || (out_item.bus_byte == CMD_PAGE_SET) || (out_item.bus_byte == CMD_MEM_WRITE))

	// After a column-set command is taken, the next result is never a command.
	`RGBW_ASSERT_NEXT(a_column_then_data, out_valid && out_ready && out_item.is_command && (out_item.bus_byte == CMD_COLUMN_SET), !out_valid || !out_item.is_command)

endmodule

[sim/rgb565_window_bus_writer_top_tb.sv]
// Self-checking testbench of the RGB565 window bus writer, with predictor, driver and monitor.
module rgb565_window_bus_writer_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rgbw_pkg::*;

	// Cycles in which no item moves on either side before the run is abandoned.
	localparam int STALL_LIMIT = 4000;
	// Length of the long receiver hold-off.
	localparam int HOLD_CYCLES = 400;
	// Cycles left for the block to settle once everything has arrived.
	localparam int DRAIN_CYCLES = 30;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_we = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	in_item_t                  in_item = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	out_item_t                 out_item;

	rgb565_window_bus_writer_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	// Clock with a 12 ns period.
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Predictor state: panel size as written and the open window.
	logic [COORD_BITS-1:0]   panel_w = PANEL_WIDTH_RESET;
	logic [COORD_BITS-1:0]   panel_h = PANEL_HEIGHT_RESET;
	logic                    win_open = 1'b0;
	logic [PIX_CNT_BITS-1:0] px_left = '0;

	// Items waiting to be offered, and bus writes still due from the block.
	in_item_t  pending_items[$];
	out_item_t due_bytes[$];

	int  in_flight = 0;
	bit  in_took = 1'b0;
	bit  out_took = 1'b0;
	bit  send_burst = 1'b0;
	bit  recv_burst = 1'b0;
	bit  hold_req = 1'b0;
	int  gap_left = 0;
	int  out_wait = 0;
	int  hold_left = 0;
	int  quiet_cycles = 0;
	int  failures = 0;
	int  items_taken = 0;
	int  bytes_checked = 0;
	int  windows_opened = 0;
	int  windows_closed = 0;
	int  windows_rejected = 0;
	int  orphan_pixels = 0;

	// Appends one expected bus write.
	function automatic void add_byte(input logic is_cmd, input logic [7:0] data,
			input logic [1:0] stat, input logic last, input logic done);
		out_item_t r;
		r.is_command  = is_cmd;
		r.bus_byte    = data;
		r.status      = stat;
		r.last_of_run = last;
		r.window_done = done;
		due_bytes.push_back(r);
	endfunction

	// Works out the bus writes that one accepted item causes.
	function automatic void expand_item(input in_item_t it);
		logic [COORD_BITS:0]   x_end;
		logic [COORD_BITS:0]   y_end;
		logic [COORD_BITS-1:0] x_last;
		logic [COORD_BITS-1:0] y_last;
		logic                  done;
		if (it.mode == MODE_WINDOW) begin
			x_end = {1'b0, it.x_start} + {1'b0, it.win_width};
			y_end = {1'b0, it.y_start} + {1'b0, it.win_height};
			if (it.win_width == '0 || it.win_height == '0 ||
					x_end > {1'b0, panel_w} || y_end > {1'b0, panel_h}) begin
				add_byte(1'b0, 8'h00, STATUS_BAD_WINDOW, 1'b1, 1'b0);
			end else begin
				x_last = COORD_BITS'(x_end - 1'b1);
				y_last = COORD_BITS'(y_end - 1'b1);
				add_byte(1'b1, CMD_COLUMN_SET, STATUS_OK, 1'b0, 1'b0);
				add_byte(1'b0, 8'(it.x_start >> 8), STATUS_OK, 1'b0, 1'b0);
				add_byte(1'b0, it.x_start[7:0], STATUS_OK, 1'b0, 1'b0);
				add_byte(1'b0, 8'(x_last >> 8), STATUS_OK, 1'b0, 1'b0);
				add_byte(1'b0, x_last[7:0], STATUS_OK, 1'b0, 1'b0);
				add_byte(1'b1, CMD_PAGE_SET, STATUS_OK, 1'b0, 1'b0);
				add_byte(1'b0, 8'(it.y_start >> 8), STATUS_OK, 1'b0, 1'b0);
				add_byte(1'b0, it.y_start[7:0], STATUS_OK, 1'b0, 1'b0);
				add_byte(1'b0, 8'(y_last >> 8), STATUS_OK, 1'b0, 1'b0);
				add_byte(1'b0, y_last[7:0], STATUS_OK, 1'b0, 1'b0);
				add_byte(1'b1, CMD_MEM_WRITE, STATUS_OK, 1'b1, 1'b0);
				win_open = 1'b1;
				px_left = PIX_CNT_BITS'(it.win_width) * PIX_CNT_BITS'(it.win_height);
			end
		end else if (!win_open) begin
			add_byte(1'b0, 8'h00, STATUS_NO_WINDOW, 1'b1, 1'b0);
		end else begin
			px_left = px_left - 1'b1;
			done = (px_left == '0);
			if (done) begin
				win_open = 1'b0;
			end
			add_byte(1'b0, 8'(it.pixel >> 8) & MASK_FIVE_BIT, STATUS_OK, 1'b0, 1'b0);
			add_byte(1'b0, 8'(it.pixel >> 3) & MASK_SIX_BIT, STATUS_OK, 1'b0, 1'b0);
			add_byte(1'b0, 8'(it.pixel << 3) & MASK_FIVE_BIT, STATUS_OK, 1'b1, done);
		end
	endfunction

	// Reports one field that differs from its expectation.
	function automatic void check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
			failures++;
		end
	endfunction

	// Queues a window item; the unused pixel field carries random bits.
	function automatic void push_window(input int x, input int y, input int w, input int h);
		in_item_t it;
		it.mode       = MODE_WINDOW;
		it.x_start    = COORD_BITS'(x);
		it.y_start    = COORD_BITS'(y);
		it.win_width  = COORD_BITS'(w);
		it.win_height = COORD_BITS'(h);
		it.pixel      = PIXEL_BITS'($urandom_range(0, 65535));
		pending_items.push_back(it);
	endfunction

	// Queues a pixel item; the unused coordinate fields carry random bits.
	function automatic void push_pixel(input int p);
		in_item_t it;
		it.mode       = MODE_PIXEL;
		it.x_start    = COORD_BITS'($urandom_range(0, 2047));
		it.y_start    = COORD_BITS'($urandom_range(0, 2047));
		it.win_width  = COORD_BITS'($urandom_range(0, 2047));
		it.win_height = COORD_BITS'($urandom_range(0, 2047));
		it.pixel      = PIXEL_BITS'(p);
		pending_items.push_back(it);
	endfunction

	// Queues one random sequence and returns how many items it holds. Most are a fitting
	// window and its pixels (up to three if it has over twelve), sometimes one short or one over.
	function automatic int queue_sequence();
		int pick;
		int w;
		int h;
		int x;
		int y;
		int count;
		int wmax;
		int hmax;
		pick = $urandom_range(0, 99);
		if (pick < 70 && panel_w != '0 && panel_h != '0) begin
			if ($urandom_range(0, 9) == 0) begin
				wmax = int'(panel_w);
				hmax = int'(panel_h);
			end else begin
				wmax = (panel_w < 4) ? int'(panel_w) : 4;
				hmax = (panel_h < 3) ? int'(panel_h) : 3;
			end
			w = $urandom_range(1, wmax);
			h = $urandom_range(1, hmax);
			x = $urandom_range(0, panel_w - w);
			y = $urandom_range(0, panel_h - h);
			count = (w * h > 12) ? $urandom_range(0, 3) : w * h;
			case ($urandom_range(0, 5))
				0: begin
					count = (count > 0) ? count - 1 : 0;
				end
				1: begin
					count = count + 1;
				end
				default: begin
				end
			endcase
			push_window(x, y, w, h);
			for (int i = 0; i < count; i++) begin
				push_pixel($urandom_range(0, 65535));
			end
			return count + 1;
		end else if (pick < 80) begin
			// A window one column or one row past the panel edge.
			if ($urandom_range(0, 1) == 1) begin
				x = $urandom_range((panel_w == 11'd2047) ? 1 : 0, panel_w);
				push_window(x, $urandom_range(0, 2047), panel_w + 1 - x,
					$urandom_range(1, 2047));
			end else begin
				y = $urandom_range((panel_h == 11'd2047) ? 1 : 0, panel_h);
				push_window($urandom_range(0, 2047), y, $urandom_range(1, 2047),
					panel_h + 1 - y);
			end
			return 1;
		end else if (pick < 90) begin
			w = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(0, 2047);
			h = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(0, 2047);
			push_window($urandom_range(0, 2047), $urandom_range(0, 2047), w, h);
			return 1;
		end else begin
			push_pixel($urandom_range(0, 65535));
			return 1;
		end
	endfunction

	// Waits until every queued item has gone in and every bus write has come out.
	task automatic wait_drained();
		while (pending_items.size() != 0 || in_flight != 0 || due_bytes.size() != 0) begin
			@(negedge clk);
		end
	endtask

	// Writes both panel registers while the block is idle.
	task automatic set_panel(input int w, input int h);
		wait_drained();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_PANEL_WIDTH;
		cfg_data  <= CFG_DATA_BITS'(w);
		@(negedge clk);
		cfg_index <= REG_PANEL_HEIGHT;
		cfg_data  <= CFG_DATA_BITS'(h);
		@(negedge clk);
		cfg_we <= 1'b0;
		panel_w = COORD_BITS'(w);
		panel_h = COORD_BITS'(h);
	endtask

	// Queues random sequences up to a number of items and lets them drain.
	task automatic run_random(input int quota);
		int added;
		added = 0;
		while (added < quota) begin
			added += queue_sequence();
		end
		wait_drained();
	endtask

	// Driver: offers the next pending item after its drawn gap.
	always @(negedge clk) begin : drive_items
		logic     next_valid;
		in_item_t next_item;
		next_valid = in_valid;
		next_item  = in_item;
		if (!in_valid || in_took) begin
			next_valid = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
			end else if (pending_items.size() != 0) begin
				next_item  = pending_items.pop_front();
				next_valid = 1'b1;
				in_flight++;
				gap_left = send_burst ? 0 : $urandom_range(0, 17);
			end
		end
		in_valid <= next_valid;
		in_item  <= next_item;
	end

	// Receiver: stalls for a drawn number of cycles after each item, or for the long hold.
	always @(negedge clk) begin
		if (out_took) begin
			out_wait = recv_burst ? 0 : $urandom_range(0, 17);
		end
		if (hold_req) begin
			hold_req  = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (out_wait > 0) begin
			out_wait--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Monitor: checks each bus write against the oldest expectation, and predicts
	// the writes of each accepted item.
	always @(posedge clk) begin : watch_ports
		out_item_t want;
		in_took  <= in_valid && in_ready;
		out_took <= out_valid && out_ready;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (due_bytes.size() == 0) begin
					$display("%0t ns: unexpected item, expected none, got 0x%0h", $time, out_item);
					failures++;
				end else begin
					want = due_bytes.pop_front();
					check_field("is_command", want.is_command, out_item.is_command);
					check_field("bus_byte", want.bus_byte, out_item.bus_byte);
					check_field("status", want.status, out_item.status);
					check_field("last_of_run", want.last_of_run, out_item.last_of_run);
					check_field("window_done", want.window_done, out_item.window_done);
					bytes_checked++;
					if (want.is_command && want.bus_byte == CMD_MEM_WRITE) begin
						windows_opened++;
					end
					if (want.window_done) begin
						windows_closed++;
					end
					if (want.status == STATUS_BAD_WINDOW) begin
						windows_rejected++;
					end
					if (want.status == STATUS_NO_WINDOW) begin
						orphan_pixels++;
					end
				end
			end
			if (in_valid && in_ready) begin
				expand_item(in_item);
				in_flight--;
				items_taken++;
			end
		end
	end

	// Watchdog on cycles in which no item moves on either side.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t ns: no item moved for %0d cycles", $time, STALL_LIMIT);
			$display("FAILED: results differ");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Stimulus sequence.
	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset panel size: error cases, edge-fitting windows and abandoned windows.
		push_pixel(16'h1234);
		push_window(0, 0, 0, 1);
		push_window(0, 0, 1, 0);
		push_window(799, 479, 1, 1);
		push_pixel(16'hFFFF);
		push_window(800, 0, 1, 1);
		push_window(0, 480, 1, 1);
		push_window(0, 0, 2, 1);
		push_pixel(16'h0000);
		push_pixel(16'hF800);
		push_pixel(16'h07E0);
		push_window(5, 6, 3, 1);
		push_pixel(16'h001F);
		push_window(300, 200, 1, 1);
		push_pixel(16'hA5A5);
		push_window(2047, 2047, 2047, 2047);
		push_window(0, 0, 800, 480);
		push_pixel(16'h5A5A);
		push_pixel(16'hFFFF);
		push_window(1, 1, 1, 1);
		push_pixel(16'h8410);
		wait_drained();

		// Largest panel: full-size window, coordinate extremes.
		set_panel(2047, 2047);
		push_window(0, 0, 2047, 2047);
		push_pixel(16'hFFFF);
		push_window(1, 0, 2047, 1);
		push_window(2046, 2046, 1, 1);
		push_pixel(16'h7BEF);
		wait_drained();
		run_random(30);

		// Smallest panel.
		set_panel(1, 1);
		push_window(0, 0, 1, 1);
		push_pixel(16'hC618);
		push_window(1, 0, 1, 1);
		wait_drained();
		run_random(20);

		// A zero panel width rejects every window.
		set_panel(0, 5);
		push_window(0, 0, 1, 1);
		wait_drained();
		run_random(15);

		// Small random panel: the receiver holds off while the sender keeps offering.
		send_burst = 1'b1;
		set_panel($urandom_range(1, 40), $urandom_range(1, 40));
		hold_req = 1'b1;
		run_random(35);
		send_burst = 1'b0;

		// Random panel anywhere in range, receiver never stalling.
		recv_burst = 1'b1;
		set_panel($urandom_range(1, 2047), $urandom_range(1, 2047));
		run_random(35);

		// Reset-sized panel with neither side idling, then with both idling.
		send_burst = 1'b1;
		set_panel(800, 480);
		run_random(30);
		send_burst = 1'b0;
		recv_burst = 1'b0;
		set_panel($urandom_range(1, 64), $urandom_range(1, 64));
		run_random(30);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (due_bytes.size() != 0) begin
			$display("%0t ns: %0d expected items never arrived", $time, due_bytes.size());
			failures++;
		end
		$display("Run: %0d items in, %0d bus writes checked, %0d mismatches.",
			items_taken, bytes_checked, failures);
		$display("Windows: %0d opened, %0d closed by their last pixel, %0d rejected;",
			windows_opened, windows_closed, windows_rejected);
		$display("Stray pixels with no window open: %0d.", orphan_pixels);
		if (failures == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
